@@ design/swm_pkg.sv @@
package swm_pkg;

    localparam int MAX_COLS_DEF   = 4096;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int MAX_ROWS       = 4096;
    localparam int ROW_BITS       = 12;

    localparam logic [62:0] SUM_TOP = {63{1'b1}};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_ROWS   = 2'd1,
        REG_COLS   = 2'd2
    } t_reg_idx;

    // Per-pixel sequencer, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_VERT = 6'b000010,
        ST_VCOL = 6'b000100,
        ST_HORZ = 6'b001000,
        ST_HSUM = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    function automatic logic [31:0] max2(input logic [31:0] a, input logic [31:0] b);
        max2 = (a > b) ? a : b;
    endfunction

    function automatic logic [31:0] max4(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
        max4 = max2(max2(a, b), max2(c, d));
    endfunction

endpackage

@@ design/sliding_window_max_2d_sum_core.sv @@
// Two-dimensional sliding-window maximum with a saturating running sum. Pixels
// arrive in raster order; for every pixel that closes a full window_size square
// window the block delivers one result beat with the window maximum, the running
// sum of window maxima in the frame and a last-window flag. Each pixel passes
// through the six-state sequencer: the line read in idle, two steps of the
// vertical max tree (the second one also shifts the column chain), two steps of
// the horizontal max tree, then the sum step that loads the output register and,
// for a pixel with a result, waits while a stalled result beat still holds it.
// A new pixel is taken once the sequencer is back in idle, even while a result
// beat waits. No clearing pass is needed after reset. A write to the window, rows
// or columns register restarts the frame.
module sliding_window_max_2d_sum_core #(
    parameter int MAX_COLS   = swm_pkg::MAX_COLS_DEF,
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
    parameter int PIXEL_BITS = swm_pkg::PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_pixel_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_window_max,
    output logic [62:0] o_running_sum,
    output logic        o_last_window,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int LW = MAX_WINDOW - 1;
    localparam int NG = (MAX_WINDOW + 3) / 4;
    localparam int RB = swm_pkg::ROW_BITS;

    // Configuration registers and their effective (clamped) values.
    logic [4:0]  r_win;
    logic [12:0] r_rows;
    logic [12:0] r_cols;
    logic [4:0]  w_k;
    logic [12:0] w_rows;
    logic [CW:0] w_cols;

    always_comb begin
        w_k = r_win;
        if (r_win == 5'd0) begin
            w_k = 5'd1;
        end else if (32'(r_win) > MAX_WINDOW) begin
            w_k = 5'(MAX_WINDOW);
        end
        w_rows = r_rows;
        if (r_rows == 13'd0) begin
            w_rows = 13'd1;
        end else if (32'(r_rows) > swm_pkg::MAX_ROWS) begin
            w_rows = 13'(swm_pkg::MAX_ROWS);
        end
        if (r_cols == 13'd0) begin
            w_cols = (CW+1)'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            w_cols = (CW+1)'(MAX_COLS);
        end else begin
            w_cols = (CW+1)'(r_cols);
        end
    end

    swm_pkg::t_state r_state, n_state;

    logic          w_in_beat;
    logic          w_cfg_beat;
    logic          w_out_free;

    // Frame position counters.
    logic [RB-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          w_row_end;
    logic          w_col_end;

    // Latched per-pixel context.
    logic [PIXEL_BITS-1:0] r_pix;
    logic [CW-1:0]         r_c;
    logic [RB-1:0]         r_r;
    logic                  r_emit;
    logic                  r_last;
    logic                  r_fend;

    logic [62:0] r_sum;
    logic [31:0] r_grp [NG];
    logic [31:0] r_wmax;

    logic        r_out_valid;
    logic [31:0] r_out_max;
    logic [62:0] r_out_sum;
    logic        r_out_last;

    assign o_in_stall  = (r_state != swm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_beat   = i_in_valid && !o_in_stall;
    assign w_cfg_beat  = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_col_end = ({1'b0, r_col} + (CW+1)'(1)) >= w_cols;
    assign w_row_end = ({1'b0, r_row} + 13'd1) >= w_rows;

    // Chain of line cells: cell i holds row r-(i+1); on the write step each cell
    // takes the word its upstream neighbor just read out.
    logic [PIXEL_BITS-1:0] w_rd [LW];

    for (genvar i = 0; i < LW; i++) begin : g_line
        logic [PIXEL_BITS-1:0] w_wd;
        if (i == 0) begin : g_first
            assign w_wd = r_pix;
        end else begin : g_next
            assign w_wd = w_rd[i-1];
        end
        swm_line_cell #(
            .ADDR_BITS (CW),
            .DATA_BITS (PIXEL_BITS)
        ) u_line (
            .i_clk   (i_clk),
            .i_rd_en (w_in_beat),
            .i_wr_en (r_state == swm_pkg::ST_VERT),
            .i_addr  (w_in_beat ? r_col : r_c),
            .i_wdata (w_wd),
            .o_rdata (w_rd[i])
        );
    end

    // Candidates for the first tree level; entries outside the window read zero.
    logic [31:0] w_vcand [NG*4];
    logic [31:0] w_hcand [NG*4];
    logic [31:0] w_gmax;

    // Chain of column cells: cell 0 takes the newest column's vertical maximum
    // straight from the second vertical tree step.
    logic [PIXEL_BITS-1:0] w_hc [MAX_WINDOW];

    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_col
        logic [PIXEL_BITS-1:0] w_hd;
        if (j == 0) begin : g_first
            assign w_hd = w_gmax[PIXEL_BITS-1:0];
        end else begin : g_next
            assign w_hd = w_hc[j-1];
        end
        swm_col_cell #(
            .DATA_BITS (PIXEL_BITS)
        ) u_col (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_state == swm_pkg::ST_VCOL),
            .i_data  (w_hd),
            .o_data  (w_hc[j])
        );
    end

    always_comb begin
        for (int i = 0; i < NG*4; i++) begin
            w_vcand[i] = '0;
            w_hcand[i] = '0;
        end
        w_vcand[0] = 32'(r_pix);
        for (int i = 0; i < LW; i++) begin
            if ((i + 1) < int'(w_k) && (i + 1) <= int'(r_r)) begin
                w_vcand[i+1] = 32'(w_rd[i]);
            end
        end
        for (int j = 0; j < MAX_WINDOW; j++) begin
            if (j < int'(w_k)) begin
                w_hcand[j] = 32'(w_hc[j]);
            end
        end
        w_gmax = '0;
        for (int g = 0; g < NG; g++) begin
            w_gmax = swm_pkg::max2(w_gmax, r_grp[g]);
        end
    end

    // Saturating accumulate.
    logic [63:0] w_sum_add;
    logic [62:0] w_sum_next;

    assign w_sum_add  = {1'b0, r_sum} + {32'd0, r_wmax};
    assign w_sum_next = w_sum_add[63] ? swm_pkg::SUM_TOP : w_sum_add[62:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    n_state = swm_pkg::ST_VERT;
                end
            end
            swm_pkg::ST_VERT: n_state = swm_pkg::ST_VCOL;
            swm_pkg::ST_VCOL: n_state = swm_pkg::ST_HORZ;
            swm_pkg::ST_HORZ: n_state = swm_pkg::ST_HSUM;
            swm_pkg::ST_HSUM: n_state = swm_pkg::ST_OUT;
            swm_pkg::ST_OUT: begin
                if (!r_emit || w_out_free) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: n_state = swm_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_IDLE;
            r_win       <= 5'd1;
            r_rows      <= 13'd4096;
            r_cols      <= 13'd4096;
            r_row       <= '0;
            r_col       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_beat) begin
                case (i_cfg_index)
                    swm_pkg::REG_WINDOW: r_win  <= i_cfg_data[4:0];
                    swm_pkg::REG_ROWS:   r_rows <= i_cfg_data;
                    swm_pkg::REG_COLS:   r_cols <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == swm_pkg::REG_WINDOW || i_cfg_index == swm_pkg::REG_ROWS
                        || i_cfg_index == swm_pkg::REG_COLS) begin
                    r_row <= '0;
                    r_col <= '0;
                    r_sum <= '0;
                end
            end else if (w_in_beat) begin
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : r_row + RB'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (r_state == swm_pkg::ST_OUT) begin
                if (r_emit && w_out_free) begin
                    r_out_valid <= 1'b1;
                    r_sum       <= r_fend ? '0 : w_sum_next;
                end else if (!r_emit && r_fend) begin
                    r_sum <= '0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_pix  <= i_pixel_value[PIXEL_BITS-1:0];
            r_c    <= r_col;
            r_r    <= r_row;
            r_emit <= (13'(r_row) + 13'd1 >= 13'(w_k))
                      && ({1'b0, r_col} + (CW+1)'(1) >= (CW+1)'(w_k));
            r_last <= w_row_end && w_col_end;
            r_fend <= w_row_end && w_col_end;
        end
        case (r_state)
            swm_pkg::ST_VERT: begin
                for (int g = 0; g < NG; g++) begin
                    r_grp[g] <= swm_pkg::max4(w_vcand[4*g], w_vcand[4*g+1],
                                              w_vcand[4*g+2], w_vcand[4*g+3]);
                end
            end
            swm_pkg::ST_HORZ: begin
                for (int g = 0; g < NG; g++) begin
                    r_grp[g] <= swm_pkg::max4(w_hcand[4*g], w_hcand[4*g+1],
                                              w_hcand[4*g+2], w_hcand[4*g+3]);
                end
            end
            swm_pkg::ST_HSUM: r_wmax <= w_gmax;
            swm_pkg::ST_OUT: begin
                if (r_emit && w_out_free) begin
                    r_out_max  <= r_wmax;
                    r_out_sum  <= w_sum_next;
                    r_out_last <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_max  = r_out_max;
    assign o_running_sum = r_out_sum;
    assign o_last_window = r_out_last;

    // The sequencer leaves idle exactly when a pixel beat is taken.
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == swm_pkg::ST_VERT))
        else $error("sequencer did not start on a pixel beat");

    // The column counter always stays inside the frame.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < w_cols))
        else $error("column counter left the frame");

    // After the last window of a frame is loaded, the sum has restarted.
    a_sum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_sum == '0))
        else $error("running sum not cleared after the last window");

endmodule

@@ design/swm_line_cell.sv @@
module swm_line_cell #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0] o_rdata
);

    // One delayed image row; the read word is handed to the next cell.
    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/swm_col_cell.sv @@
module swm_col_cell #(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [DATA_BITS-1:0] i_data,
    output logic [DATA_BITS-1:0] o_data
);

    // Holds the vertical maximum of one recent column.
    logic [DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int LINE_ROWS   = swm_pkg::MAX_WINDOW_DEF - 1;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 20;
    localparam int ITEM_TARGET = 1050;

    typedef struct packed {
        logic [31:0] window_max;
        logic [62:0] running_sum;
        logic        last_window;
    } t_win_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] pixel = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = swm_pkg::REG_WINDOW;
    logic [12:0] cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_window_max;
    logic [62:0] o_running_sum;
    logic        o_last_window;
    logic        o_cfg_ready;

    sliding_window_max_2d_sum_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_value(pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_window_max (o_window_max),
        .o_running_sum(o_running_sum),
        .o_last_window(o_last_window),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Pixels waiting to be driven, and window results waiting to arrive.
    logic [31:0] pixel_q[$];
    t_win_result window_q[$];
    logic        hold_input = 1'b0;

    // Shadow of the block's configuration and frame state.
    logic [4:0]  win_reg;
    logic [12:0] rows_reg;
    logic [12:0] cols_reg;
    logic [31:0] line_store [0:LINE_ROWS*swm_pkg::MAX_COLS_DEF-1];
    logic [31:0] col_cells [0:swm_pkg::MAX_WINDOW_DEF-1];
    int unsigned row_cnt;
    int unsigned col_cnt;
    logic [62:0] sum_reg;

    int unsigned errors = 0;
    int unsigned pixels_seen = 0;
    int unsigned windows_seen = 0;
    int unsigned frames_done = 0;
    int unsigned cfg_writes = 0;

    // Apply one register write to the shadow; a write to a real register
    // restarts the frame, a write to the unused index changes nothing.
    task automatic apply_cfg(input logic [1:0] idx, input logic [12:0] data);
        case (swm_pkg::t_reg_idx'(idx))
            swm_pkg::REG_WINDOW: begin
                win_reg = data[4:0];
            end
            swm_pkg::REG_ROWS: begin
                rows_reg = data;
            end
            swm_pkg::REG_COLS: begin
                cols_reg = data;
            end
            default: begin
                return;
            end
        endcase
        row_cnt = 0;
        col_cnt = 0;
        sum_reg = '0;
    endtask

    // Compute the window result that a pixel causes, if any.
    task automatic predict_window(input logic [31:0] pix);
        int unsigned k, rows, cols, r, c, d, j;
        logic [31:0] vmax, wmax, v;
        logic [63:0] s;
        t_win_result res;
        // Zero sizes act as one, oversized ones clamp to the hardware limits.
        k = (win_reg == 0) ? 1 :
            (win_reg > swm_pkg::MAX_WINDOW_DEF) ? swm_pkg::MAX_WINDOW_DEF : win_reg;
        rows = (rows_reg == 0) ? 1 :
               (rows_reg > swm_pkg::MAX_ROWS) ? swm_pkg::MAX_ROWS : rows_reg;
        cols = (cols_reg == 0) ? 1 :
               (cols_reg > swm_pkg::MAX_COLS_DEF) ? swm_pkg::MAX_COLS_DEF : cols_reg;
        r = (row_cnt >= rows) ? rows - 1 : row_cnt;
        c = (col_cnt >= cols) ? cols - 1 : col_cnt;
        // Vertical maximum over the last k rows of this column.
        vmax = pix;
        for (d = 1; d < k && d <= r; d++) begin
            v = line_store[((r - d) % LINE_ROWS) * swm_pkg::MAX_COLS_DEF + c];
            if (v > vmax) vmax = v;
        end
        col_cells[c % swm_pkg::MAX_WINDOW_DEF] = vmax;
        line_store[(r % LINE_ROWS) * swm_pkg::MAX_COLS_DEF + c] = pix;
        // Horizontal maximum over the last k column maxima.
        if (r + 1 >= k && c + 1 >= k) begin
            wmax = '0;
            for (j = 0; j < k; j++) begin
                v = col_cells[(c - j) % swm_pkg::MAX_WINDOW_DEF];
                if (v > wmax) wmax = v;
            end
            s = {1'b0, sum_reg};
            if (s > {1'b0, swm_pkg::SUM_TOP} - {32'd0, wmax}) s = {1'b0, swm_pkg::SUM_TOP};
            else s = s + {32'd0, wmax};
            sum_reg = s[62:0];
            res.window_max = wmax;
            res.running_sum = sum_reg;
            res.last_window = (r == rows - 1 && c == cols - 1);
            window_q.push_back(res);
        end
        if (c + 1 >= cols) begin
            col_cnt = 0;
            if (r + 1 >= rows) begin
                row_cnt = 0;
                sum_reg = '0;
                frames_done++;
            end else begin
                row_cnt = r + 1;
            end
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    // Predict on accepted pixel beats and configuration writes, check
    // accepted result beats against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg = 5'd1;
            rows_reg = 13'd4096;
            cols_reg = 13'd4096;
            row_cnt = 0;
            col_cnt = 0;
            sum_reg = '0;
            for (int i = 0; i < swm_pkg::MAX_WINDOW_DEF; i++) col_cells[i] = '0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                apply_cfg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (in_valid && !o_in_stall) begin
                predict_window(pixel);
                pixels_seen++;
            end
            if (o_out_valid && !out_stall) begin
                windows_seen++;
                if (window_q.size() == 0) begin
                    $error("result beat with no window expected (max %h)", o_window_max);
                    errors++;
                end else begin
                    t_win_result want;
                    want = window_q.pop_front();
                    if (o_window_max !== want.window_max) begin
                        $error("window_max: expected %h, got %h",
                               want.window_max, o_window_max);
                        errors++;
                    end
                    if (o_running_sum !== want.running_sum) begin
                        $error("running_sum: expected %h, got %h",
                               want.running_sum, o_running_sum);
                        errors++;
                    end
                    if (o_last_window !== want.last_window) begin
                        $error("last_window: expected %b, got %b",
                               want.last_window, o_last_window);
                        errors++;
                    end
                end
            end
        end
    end

    // Pixel driver: bursts of random length separated by random gaps. A
    // new beat is only loaded when the current one was taken or none is up.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pixel_q.size() > 0 && !hold_input) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                pixel <= pixel_q.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: the stall mode is drawn at random, from no stall at all
    // through light and heavy random stalls to a fixed pattern.
    int unsigned stall_phase = 0;
    int unsigned stall_mode = 0;
    always @(posedge i_clk) begin
        stall_phase++;
        if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= (stall_phase % 5 < 2);
        endcase
    end

    // Watchdog on cycles in which no channel moves a beat.
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || in_valid || window_q.size() != 0);
        // Pixels that close no window may still be in flight.
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input swm_pkg::t_reg_idx idx, input logic [12:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Configure all three registers once the block is idle.
    task automatic set_frame(input logic [12:0] w, input logic [12:0] rows,
                             input logic [12:0] cols);
        wait_drained();
        cfg_write(swm_pkg::REG_WINDOW, w);
        cfg_write(swm_pkg::REG_ROWS, rows);
        cfg_write(swm_pkg::REG_COLS, cols);
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned queued;
        int unsigned holds;
        int unsigned w, rows, cols, n;
        queued = 0;
        holds = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unit window over a full-size frame, extremes of the pixel.
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'hFFFF_FFFF);
        pixel_q.push_back(32'hAAAA_AAAA);
        pixel_q.push_back(32'h5555_5555);
        queued += 4;

        // Zero window, rows and columns act as one: every pixel is a last window.
        set_frame(13'd0, 13'd0, 13'd0);
        repeat (3) pixel_q.push_back(rand_pixel());
        queued += 3;

        // Window wider than the frame: no results, but the frame still wraps.
        set_frame(13'd5, 13'd2, 13'd3);
        repeat (6) pixel_q.push_back(rand_pixel());
        queued += 6;

        // Oversized window, rows and columns saturate to the hardware limits.
        set_frame(13'd31, 13'd8191, 13'd8191);
        repeat (3) pixel_q.push_back(rand_pixel());
        queued += 3;

        // Small 3x3 window over a 3x4 frame, then an unused register index
        // that must leave the frame untouched.
        set_frame(13'd3, 13'd3, 13'd4);
        repeat (6) pixel_q.push_back(rand_pixel());
        queued += 6;
        wait_drained();
        cfg_write(swm_pkg::t_reg_idx'(2'd3), 13'h1FFF);
        repeat (6) pixel_q.push_back(rand_pixel());
        queued += 6;

        // Random part: mostly small frames, a few with the largest window.
        while (queued < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                w = swm_pkg::MAX_WINDOW_DEF;
                rows = $urandom_range(16, 18);
                cols = $urandom_range(16, 20);
            end else begin
                w = $urandom_range(0, 4);
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 8);
            end
            if ($urandom_range(0, 3) == 0) begin
                // Only one register changes; the others keep their value.
                wait_drained();
                cfg_write(swm_pkg::REG_WINDOW, w[12:0]);
                rows = rows_reg;
                cols = cols_reg;
                if (rows == 0) rows = 1;
                if (cols == 0) cols = 1;
                if (rows > 20) rows = 20;
            end else begin
                set_frame(w[12:0], rows[12:0], cols[12:0]);
            end
            // One to three frames, sometimes cut short by the next write.
            n = rows * cols * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            if (n > 400) n = 400;
            if (n > ITEM_TARGET - queued) n = ITEM_TARGET - queued;
            for (int i = 0; i < n; i++) pixel_q.push_back(rand_pixel());
            queued += n;
            // Now and then, and at least once, hold the sender until every
            // result is back.
            if (holds == 0 || $urandom_range(0, 7) == 0) begin
                holds++;
                hold_input = 1'b1;
                do @(posedge i_clk);
                while (window_q.size() != 0 || in_valid);
                repeat (DRAIN_WAIT) @(posedge i_clk);
                hold_input = 1'b0;
            end
        end

        wait_drained();
        $display("Covered %0d pixel beats, %0d window results, %0d whole frames,",
                 pixels_seen, windows_seen, frames_done);
        $display("and %0d register writes across window sizes 0 to 31.", cfg_writes);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
